[rtl/amdfs_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the DFS core.
package amdfs_pkg;

  localparam int MAX_VERTS = 64;
  localparam int VID_W     = 6;
  localparam int CNT_W     = 7;
  localparam int CMD_W     = 2;
  localparam int WEIGHT_W  = 16;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTS);

  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_RD_A,
    ST_EDGE_WR_A,
    ST_EDGE_RD_B,
    ST_EDGE_WR_B,
    ST_SRCH_RD,
    ST_SRCH_SCAN,
    ST_SRCH_POP
  } state_t;

  typedef enum logic [1:0] {
    RSEL_A,
    RSEL_B,
    RSEL_TOP,
    RSEL_STK
  } row_sel_t;

  typedef struct packed {
    logic     load;
    logic     clr_rows;
    logic     row_rd;
    row_sel_t row_sel;
    logic     row_wr;
    logic     wr_sel_b;
    logic     srch_init;
    logic     scan;
    logic     pop;
  } ctrl_t;

  typedef struct packed {
    logic a_ok;
    logic b_ok;
    logic found;
    logic depth_one;
  } stat_t;

endpackage

[rtl/amdfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module amdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/amdfs_dp.sv]
// Datapath: adjacency rows, visited marks, vertex stack, candidate encoder and result register.
module amdfs_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  amdfs_pkg::ctrl_t                      ctrl,
  output amdfs_pkg::stat_t                      stat,
  input  logic [amdfs_pkg::VID_W-1:0]           in_vertex_a,
  input  logic [amdfs_pkg::VID_W-1:0]           in_vertex_b,
  input  logic signed [amdfs_pkg::WEIGHT_W-1:0] in_weight,
  input  logic                                  cfg_wr_en,
  input  logic [amdfs_pkg::CNT_W-1:0]           cfg_vertex_count,
  output logic                                  out_strobe,
  output logic [amdfs_pkg::VID_W-1:0]           out_visited_vertex,
  output logic                                  out_last
);

  logic [amdfs_pkg::CNT_W-1:0]     vcount_r;
  logic [amdfs_pkg::CNT_W-1:0]     n_act;
  logic [amdfs_pkg::MAX_VERTS-1:0] nmask;

  logic [amdfs_pkg::VID_W-1:0]     a_r;
  logic [amdfs_pkg::VID_W-1:0]     b_r;
  logic                            present_r;

  logic [amdfs_pkg::MAX_VERTS-1:0] row_vld_r;
  logic                            rowv_r;
  logic [amdfs_pkg::VID_W-1:0]     row_raddr;
  logic [amdfs_pkg::VID_W-1:0]     row_waddr;
  logic [amdfs_pkg::VID_W-1:0]     row_wbit;
  logic [amdfs_pkg::MAX_VERTS-1:0] row_rdata;
  logic [amdfs_pkg::MAX_VERTS-1:0] row_q;
  logic [amdfs_pkg::MAX_VERTS-1:0] row_wdata;

  logic [amdfs_pkg::MAX_VERTS-1:0] visited_r;
  logic [amdfs_pkg::VID_W-1:0]     top_r;
  logic [amdfs_pkg::CNT_W-1:0]     depth_r;
  logic [amdfs_pkg::VID_W-1:0]     pend_r;

  logic [amdfs_pkg::MAX_VERTS-1:0] cand;
  logic                            found;
  logic [amdfs_pkg::VID_W-1:0]     pick;
  logic                            depth_one;

  logic                            stk_wr;
  logic [amdfs_pkg::VID_W-1:0]     stk_waddr;
  logic                            stk_rd;
  logic [amdfs_pkg::VID_W-1:0]     stk_raddr;
  logic [amdfs_pkg::CNT_W-1:0]     depth_m1;
  logic [amdfs_pkg::CNT_W-1:0]     depth_m2;
  logic [amdfs_pkg::VID_W-1:0]     stk_rdata;

  logic                            out_vld_r;
  logic [amdfs_pkg::VID_W-1:0]     out_vtx_r;
  logic                            out_last_r;

  // Active vertex count, saturated to the matrix size
  assign n_act = (vcount_r > amdfs_pkg::MAX_CNT) ? amdfs_pkg::MAX_CNT : vcount_r;

  always_comb begin
    for (int i = 0; i < amdfs_pkg::MAX_VERTS; i++) begin
      nmask[i] = (amdfs_pkg::CNT_W'(i) < n_act);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= amdfs_pkg::MAX_CNT;
    end else if (cfg_wr_en) begin
      vcount_r <= cfg_vertex_count;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_r       <= in_vertex_a;
      b_r       <= in_vertex_b;
      present_r <= (in_weight != '0);
    end
  end

  // Row memory address and read-modify-write data
  always_comb begin
    case (ctrl.row_sel)
      amdfs_pkg::RSEL_A:   row_raddr = a_r;
      amdfs_pkg::RSEL_B:   row_raddr = b_r;
      amdfs_pkg::RSEL_TOP: row_raddr = top_r;
      default:             row_raddr = stk_rdata;
    endcase
  end

  assign row_waddr = ctrl.wr_sel_b ? b_r : a_r;
  assign row_wbit  = ctrl.wr_sel_b ? a_r : b_r;
  // A row that was never written since the last clear reads as empty
  assign row_q     = rowv_r ? row_rdata : '0;
  assign row_wdata = present_r
                   ? (row_q | (amdfs_pkg::MAX_VERTS'(1) << row_wbit))
                   : (row_q & ~(amdfs_pkg::MAX_VERTS'(1) << row_wbit));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (ctrl.clr_rows) begin
      row_vld_r <= '0;
    end else if (ctrl.row_wr) begin
      row_vld_r[row_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.row_rd) begin
      rowv_r <= row_vld_r[row_raddr];
    end
  end

  amdfs_ram #(
    .WIDTH (amdfs_pkg::MAX_VERTS),
    .DEPTH (amdfs_pkg::MAX_VERTS)
  ) u_rows (
    .clk     (clk),
    .wr_en   (ctrl.row_wr),
    .wr_addr (row_waddr),
    .wr_data (row_wdata),
    .rd_en   (ctrl.row_rd),
    .rd_addr (row_raddr),
    .rd_data (row_rdata)
  );

  // Lowest-index unvisited neighbor of the top vertex
  assign cand      = row_q & ~visited_r & nmask;
  assign found     = |cand;
  assign depth_one = (depth_r == amdfs_pkg::CNT_W'(1));

  always_comb begin
    pick = '0;
    for (int i = amdfs_pkg::MAX_VERTS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick = amdfs_pkg::VID_W'(i);
      end
    end
  end

  // Stack holds the entries below the top vertex
  assign depth_m1  = depth_r - amdfs_pkg::CNT_W'(1);
  assign depth_m2  = depth_r - amdfs_pkg::CNT_W'(2);
  assign stk_wr    = ctrl.scan & found;
  assign stk_waddr = depth_m1[amdfs_pkg::VID_W-1:0];
  assign stk_rd    = ctrl.scan & ~found & ~depth_one;
  assign stk_raddr = depth_m2[amdfs_pkg::VID_W-1:0];

  amdfs_ram #(
    .WIDTH (amdfs_pkg::VID_W),
    .DEPTH (amdfs_pkg::MAX_VERTS)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr),
    .wr_addr (stk_waddr),
    .wr_data (top_r),
    .rd_en   (stk_rd),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (ctrl.srch_init) begin
      depth_r <= amdfs_pkg::CNT_W'(1);
    end else if (ctrl.scan) begin
      depth_r <= found ? depth_r + amdfs_pkg::CNT_W'(1) : depth_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.srch_init) begin
      visited_r <= amdfs_pkg::MAX_VERTS'(1) << in_vertex_a;
      top_r     <= in_vertex_a;
      pend_r    <= in_vertex_a;
    end else if (ctrl.scan && found) begin
      visited_r <= visited_r | (amdfs_pkg::MAX_VERTS'(1) << pick);
      top_r     <= pick;
      pend_r    <= pick;
    end else if (ctrl.pop) begin
      top_r <= stk_rdata;
    end
  end

  // Emit each vertex one step late so the final one can carry the last flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= ctrl.scan & (found | depth_one);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan) begin
      out_vtx_r  <= pend_r;
      out_last_r <= ~found;
    end
  end

  assign out_strobe         = out_vld_r;
  assign out_visited_vertex = out_vtx_r;
  assign out_last           = out_last_r;

  assign stat.a_ok      = ({1'b0, in_vertex_a} < n_act);
  assign stat.b_ok      = ({1'b0, in_vertex_b} < n_act);
  assign stat.found     = found;
  assign stat.depth_one = depth_one;

endmodule

[rtl/amdfs_ctrl.sv]
// Controller: command decode and sequencing of edge updates and the search walk.
module amdfs_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [amdfs_pkg::CMD_W-1:0]      in_command,
  input  amdfs_pkg::stat_t                 stat,
  output amdfs_pkg::ctrl_t                 ctrl,
  output logic                             busy
);

  amdfs_pkg::state_t state_r;
  amdfs_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= amdfs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    busy      = (state_r != amdfs_pkg::ST_IDLE);
    unique case (state_r)
      amdfs_pkg::ST_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          unique case (in_command)
            amdfs_pkg::CMD_CLEAR: begin
              ctrl.clr_rows = 1'b1;
            end
            amdfs_pkg::CMD_ADD_EDGE: begin
              if (stat.a_ok && stat.b_ok) begin
                state_nxt = amdfs_pkg::ST_EDGE_RD_A;
              end
            end
            amdfs_pkg::CMD_SEARCH: begin
              if (stat.a_ok) begin
                ctrl.srch_init = 1'b1;
                state_nxt      = amdfs_pkg::ST_SRCH_RD;
              end
            end
            default: begin
              // drop unused command
            end
          endcase
        end
      end
      amdfs_pkg::ST_EDGE_RD_A: begin
        ctrl.row_rd  = 1'b1;
        ctrl.row_sel = amdfs_pkg::RSEL_A;
        state_nxt    = amdfs_pkg::ST_EDGE_WR_A;
      end
      amdfs_pkg::ST_EDGE_WR_A: begin
        ctrl.row_wr = 1'b1;
        state_nxt   = amdfs_pkg::ST_EDGE_RD_B;
      end
      amdfs_pkg::ST_EDGE_RD_B: begin
        ctrl.row_rd  = 1'b1;
        ctrl.row_sel = amdfs_pkg::RSEL_B;
        state_nxt    = amdfs_pkg::ST_EDGE_WR_B;
      end
      amdfs_pkg::ST_EDGE_WR_B: begin
        ctrl.row_wr   = 1'b1;
        ctrl.wr_sel_b = 1'b1;
        state_nxt     = amdfs_pkg::ST_IDLE;
      end
      amdfs_pkg::ST_SRCH_RD: begin
        ctrl.row_rd  = 1'b1;
        ctrl.row_sel = amdfs_pkg::RSEL_TOP;
        state_nxt    = amdfs_pkg::ST_SRCH_SCAN;
      end
      amdfs_pkg::ST_SRCH_SCAN: begin
        ctrl.scan = 1'b1;
        if (stat.found) begin
          state_nxt = amdfs_pkg::ST_SRCH_RD;
        end else if (stat.depth_one) begin
          state_nxt = amdfs_pkg::ST_IDLE;
        end else begin
          state_nxt = amdfs_pkg::ST_SRCH_POP;
        end
      end
      amdfs_pkg::ST_SRCH_POP: begin
        // advance to the popped vertex and fetch its row
        ctrl.pop     = 1'b1;
        ctrl.row_rd  = 1'b1;
        ctrl.row_sel = amdfs_pkg::RSEL_STK;
        state_nxt    = amdfs_pkg::ST_SRCH_SCAN;
      end
      default: begin
        state_nxt = amdfs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/adjacency_matrix_dfs_core.sv]
// Top level of the adjacency-matrix depth-first search core.
// Usage:
//   A request is taken at a clock edge with start high and busy low. in_command
//   selects clear (matrix emptied in that cycle, busy stays low), add edge
//   (both symmetric entries rewritten, busy while each row is read and then
//   written, skipped when an endpoint is at or above the vertex count) or search
//   from in_vertex_a. A search emits each visited vertex on out_visited_vertex
//   for one cycle with out_strobe high; out_last marks the final vertex. An
//   out-of-range start vertex or the unused command gives no results and no
//   busy time. Each result is presented one walk step after its vertex is
//   found, so the last one can carry out_last; the first result is driven after
//   the start vertex's row read and first scan. Each vertex pushed costs a row
//   read, then a scan; each backtrack costs a stack read, then a scan. busy
//   falls in the cycle the last result is driven. The receiver has no stall:
//   results are never held. cfg_wr_en writes cfg_vertex_count (values above 64
//   act as 64); the user must write it only while idle, as the core does not
//   enforce this. After reset the matrix is empty (row valid bits, no clearing
//   pass) and the vertex count is 64.
module adjacency_matrix_dfs_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [amdfs_pkg::CMD_W-1:0]           in_command,
  input  logic [amdfs_pkg::VID_W-1:0]           in_vertex_a,
  input  logic [amdfs_pkg::VID_W-1:0]           in_vertex_b,
  input  logic signed [amdfs_pkg::WEIGHT_W-1:0] in_weight,
  input  logic                                  cfg_wr_en,
  input  logic [amdfs_pkg::CNT_W-1:0]           cfg_vertex_count,
  output logic                                  out_strobe,
  output logic [amdfs_pkg::VID_W-1:0]           out_visited_vertex,
  output logic                                  out_last
);

  amdfs_pkg::ctrl_t ctrl;
  amdfs_pkg::stat_t stat;

  amdfs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .ctrl       (ctrl),
    .busy       (busy)
  );

  amdfs_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .stat               (stat),
    .in_vertex_a        (in_vertex_a),
    .in_vertex_b        (in_vertex_b),
    .in_weight          (in_weight),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_vertex_count   (cfg_vertex_count),
    .out_strobe         (out_strobe),
    .out_visited_vertex (out_visited_vertex),
    .out_last           (out_last)
  );

endmodule

[test/adjacency_matrix_dfs_core_test.sv]
// Self-checking testbench for the adjacency-matrix depth-first search core.
module adjacency_matrix_dfs_core_test;

  localparam logic [amdfs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic [amdfs_pkg::VID_W-1:0] vertex;
    logic                        last;
  } visit_t;

  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  start = 1'b0;
  logic                                  busy;
  logic [amdfs_pkg::CMD_W-1:0]           in_command = '0;
  logic [amdfs_pkg::VID_W-1:0]           in_vertex_a = '0;
  logic [amdfs_pkg::VID_W-1:0]           in_vertex_b = '0;
  logic signed [amdfs_pkg::WEIGHT_W-1:0] in_weight = '0;
  logic                                  cfg_wr_en = 1'b0;
  logic [amdfs_pkg::CNT_W-1:0]           cfg_vertex_count = '0;
  logic                                  out_strobe;
  logic [amdfs_pkg::VID_W-1:0]           out_visited_vertex;
  logic                                  out_last;

  // predictor state
  logic [amdfs_pkg::MAX_VERTS-1:0] link_rows [amdfs_pkg::MAX_VERTS];
  logic [amdfs_pkg::CNT_W-1:0]     vertex_count_now;
  visit_t                          expected_visits [$];

  int error_count = 0;
  int requests_sent = 0;
  int effective_requests = 0;
  int searches_sent = 0;
  int visits_checked = 0;
  int idle_pct = 27;

  adjacency_matrix_dfs_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_vertex_a        (in_vertex_a),
    .in_vertex_b        (in_vertex_b),
    .in_weight          (in_weight),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_vertex_count   (cfg_vertex_count),
    .out_strobe         (out_strobe),
    .out_visited_vertex (out_visited_vertex),
    .out_last           (out_last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("MISMATCH: %s", what);
    end
  endtask

  function automatic int active_vertices();
    return (vertex_count_now > amdfs_pkg::MAX_CNT) ? amdfs_pkg::MAX_VERTS
                                                   : int'(vertex_count_now);
  endfunction

  // Preorder walk trying neighbors in ascending order; queue the visits.
  function automatic void predict_walk(input logic [amdfs_pkg::VID_W-1:0] root);
    logic [amdfs_pkg::MAX_VERTS-1:0] seen;
    logic [amdfs_pkg::VID_W-1:0]     path_vertex [amdfs_pkg::MAX_VERTS];
    int                              path_next [amdfs_pkg::MAX_VERTS];
    int                              depth;
    int                              n;
    int                              nb;
    logic [amdfs_pkg::VID_W-1:0]     v;
    visit_t                          found [$];
    n = active_vertices();
    seen = '0;
    seen[root] = 1'b1;
    found.push_back(visit_t'{vertex: root, last: 1'b0});
    path_vertex[0] = root;
    path_next[0] = 0;
    depth = 1;
    while (depth > 0) begin
      v = path_vertex[depth-1];
      nb = path_next[depth-1];
      while (nb < n && (!link_rows[v][nb] || seen[nb])) nb++;
      if (nb >= n) begin
        depth--;
      end else begin
        path_next[depth-1] = nb + 1;
        seen[nb] = 1'b1;
        found.push_back(visit_t'{vertex: amdfs_pkg::VID_W'(nb), last: 1'b0});
        path_vertex[depth] = amdfs_pkg::VID_W'(nb);
        path_next[depth] = 0;
        depth++;
      end
    end
    found[found.size()-1].last = 1'b1;
    foreach (found[k]) expected_visits.push_back(found[k]);
  endfunction

  // Update the predictor for one accepted request; return 1 if it did anything.
  function automatic bit apply_request(input logic [amdfs_pkg::CMD_W-1:0] cmd,
                                       input logic [amdfs_pkg::VID_W-1:0] a,
                                       input logic [amdfs_pkg::VID_W-1:0] b,
                                       input logic [amdfs_pkg::WEIGHT_W-1:0] w);
    int n;
    n = active_vertices();
    case (cmd)
      amdfs_pkg::CMD_CLEAR: begin
        foreach (link_rows[r]) link_rows[r] = '0;
        return 1'b1;
      end
      amdfs_pkg::CMD_ADD_EDGE: begin
        if (a < n && b < n) begin
          link_rows[a][b] = (w != '0);
          link_rows[b][a] = (w != '0);
          return 1'b1;
        end
        return 1'b0;
      end
      amdfs_pkg::CMD_SEARCH: begin
        if (a < n) begin
          predict_walk(a);
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_request(input logic [amdfs_pkg::CMD_W-1:0] cmd,
                              input logic [amdfs_pkg::VID_W-1:0] a,
                              input logic [amdfs_pkg::VID_W-1:0] b,
                              input logic [amdfs_pkg::WEIGHT_W-1:0] w);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_command  <= cmd;
    in_vertex_a <= a;
    in_vertex_b <= b;
    in_weight   <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
    if (cmd == amdfs_pkg::CMD_SEARCH) searches_sent++;
    if (apply_request(cmd, a, b, w)) effective_requests++;
  endtask

  // Hold off requests until every visit is in and the core has gone quiet.
  task automatic wait_for_visits();
    start <= 1'b0;
    while (expected_visits.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [amdfs_pkg::CNT_W-1:0] value);
    wait_for_visits();
    cfg_wr_en        <= 1'b1;
    cfg_vertex_count <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    vertex_count_now = value;
  endtask

  function automatic logic [amdfs_pkg::WEIGHT_W-1:0] pick_weight();
    int r;
    logic [amdfs_pkg::WEIGHT_W-1:0] w;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 20) return 16'h8000;
    if (r < 25) return 16'h7FFF;
    w = amdfs_pkg::WEIGHT_W'($urandom);
    return (w == '0) ? 16'h0001 : w;
  endfunction

  function automatic logic [amdfs_pkg::VID_W-1:0] pick_vertex(input int n);
    if (n == 0 || $urandom_range(99) < 10) begin
      return amdfs_pkg::VID_W'($urandom_range(0, 63));
    end
    return amdfs_pkg::VID_W'($urandom_range(0, n - 1));
  endfunction

  task automatic test_reset_state();
    send_request(amdfs_pkg::CMD_SEARCH, 6'd0, 6'd63, 16'hFFFF);
    send_request(amdfs_pkg::CMD_SEARCH, 6'd63, 6'd0, 16'h0000);
  endtask

  task automatic test_link_updates();
    send_request(amdfs_pkg::CMD_ADD_EDGE, 6'd0, 6'd63, 16'h7FFF);
    send_request(amdfs_pkg::CMD_ADD_EDGE, 6'd0, 6'd1, 16'h8000);
    send_request(amdfs_pkg::CMD_ADD_EDGE, 6'd5, 6'd5, 16'h0001);
    send_request(amdfs_pkg::CMD_ADD_EDGE, 6'd1, 6'd62, 16'hFFFF);
    send_request(amdfs_pkg::CMD_SEARCH, 6'd0, 6'd0, 16'h0000);
    wait_for_visits();
    // zero weight removes the link
    send_request(amdfs_pkg::CMD_ADD_EDGE, 6'd0, 6'd1, 16'h0000);
    send_request(amdfs_pkg::CMD_SEARCH, 6'd1, 6'd42, 16'h1234);
    send_request(CMD_UNUSED, 6'd0, 6'd63, 16'hA5A5);
    send_request(amdfs_pkg::CMD_SEARCH, 6'd5, 6'd5, 16'h0000);
    send_request(amdfs_pkg::CMD_CLEAR, 6'd63, 6'd63, 16'hFFFF);
    send_request(amdfs_pkg::CMD_SEARCH, 6'd63, 6'd0, 16'h0000);
  endtask

  task automatic test_vertex_count_limits();
    write_vertex_count(7'd127);
    send_request(amdfs_pkg::CMD_ADD_EDGE, 6'd63, 6'd2, 16'h0040);
    send_request(amdfs_pkg::CMD_SEARCH, 6'd63, 6'd0, 16'h0000);
    write_vertex_count(7'd0);
    send_request(amdfs_pkg::CMD_ADD_EDGE, 6'd0, 6'd0, 16'h0001);
    send_request(amdfs_pkg::CMD_SEARCH, 6'd0, 6'd0, 16'h0000);
    write_vertex_count(7'd64);
    send_request(amdfs_pkg::CMD_CLEAR, 6'd0, 6'd0, 16'h0000);
    send_request(amdfs_pkg::CMD_ADD_EDGE, 6'd1, 6'd40, 16'h0100);
    write_vertex_count(7'd8);
    send_request(amdfs_pkg::CMD_ADD_EDGE, 6'd2, 6'd9, 16'h0001);
    send_request(amdfs_pkg::CMD_ADD_EDGE, 6'd3, 6'd2, 16'h0002);
    send_request(amdfs_pkg::CMD_SEARCH, 6'd9, 6'd0, 16'h0000);
    send_request(amdfs_pkg::CMD_SEARCH, 6'd1, 6'd0, 16'h0000);
    send_request(amdfs_pkg::CMD_SEARCH, 6'd3, 6'd0, 16'h0000);
    write_vertex_count(7'd64);
    send_request(amdfs_pkg::CMD_SEARCH, 6'd1, 6'd0, 16'h0000);
  endtask

  task automatic test_random_graphs();
    int first_count;
    int round;
    int n;
    int r;
    int links;
    int walks;
    int chain_len;
    logic [amdfs_pkg::MAX_VERTS-1:0] used;
    logic [amdfs_pkg::VID_W-1:0]     chain [$];
    logic [amdfs_pkg::VID_W-1:0]     v;
    logic [amdfs_pkg::CNT_W-1:0]     count_value;
    first_count = effective_requests;
    round = 0;
    while (effective_requests - first_count < 70) begin
      // one round runs the sender flat out
      idle_pct = (round == 2) ? 0 : 27;
      r = $urandom_range(99);
      if (round == 1) count_value = 7'd64;
      else if (r < 45) count_value = amdfs_pkg::CNT_W'($urandom_range(2, 8));
      else if (r < 75) count_value = amdfs_pkg::CNT_W'($urandom_range(9, 24));
      else if (r < 87) count_value = 7'd64;
      else if (r < 95) count_value = amdfs_pkg::CNT_W'($urandom_range(65, 127));
      else count_value = amdfs_pkg::CNT_W'($urandom_range(0, 1));
      write_vertex_count(count_value);
      send_request(amdfs_pkg::CMD_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
      n = active_vertices();
      if (round == 1) begin
        // long chain over scattered vertices drives the stack deep
        used = '0;
        chain.delete();
        chain_len = $urandom_range(24, 40);
        while (chain.size() < chain_len) begin
          v = amdfs_pkg::VID_W'($urandom_range(0, 63));
          if (!used[v]) begin
            used[v] = 1'b1;
            chain.push_back(v);
          end
        end
        for (int k = 1; k < chain.size(); k++) begin
          send_request(amdfs_pkg::CMD_ADD_EDGE, chain[k-1], chain[k],
                       16'h0001 | 16'($urandom));
        end
        send_request(amdfs_pkg::CMD_SEARCH, chain[0], 6'($urandom), 16'($urandom));
        send_request(amdfs_pkg::CMD_SEARCH, chain[chain.size()/2], 6'($urandom),
                     16'($urandom));
      end else begin
        links = $urandom_range(2, 14);
        for (int k = 0; k < links; k++) begin
          r = $urandom_range(99);
          if (r < 4) begin
            send_request(CMD_UNUSED, 6'($urandom), 6'($urandom), 16'($urandom));
          end else if (r < 6) begin
            send_request(amdfs_pkg::CMD_CLEAR, 6'($urandom), 6'($urandom),
                         16'($urandom));
          end else begin
            send_request(amdfs_pkg::CMD_ADD_EDGE, pick_vertex(n), pick_vertex(n),
                         pick_weight());
          end
          if ($urandom_range(99) < 12) begin
            send_request(amdfs_pkg::CMD_SEARCH, pick_vertex(n), 6'($urandom),
                         16'($urandom));
          end
        end
        walks = $urandom_range(1, 3);
        for (int k = 0; k < walks; k++) begin
          send_request(amdfs_pkg::CMD_SEARCH, pick_vertex(n), 6'($urandom),
                       16'($urandom));
        end
      end
      round++;
    end
    idle_pct = 27;
  endtask

  // result checker: the core cannot be stalled, so every strobe is a result
  always @(posedge clk) begin
    visit_t want;
    if (rst_n && out_strobe) begin
      if (expected_visits.size() == 0) begin
        report_mismatch($sformatf("unexpected visit %0d last=%0b",
                                  out_visited_vertex, out_last));
      end else begin
        want = expected_visits.pop_front();
        visits_checked++;
        if (out_visited_vertex !== want.vertex) begin
          report_mismatch($sformatf("visited_vertex %0d, expected %0d",
                                    out_visited_vertex, want.vertex));
        end
        if (out_last !== want.last) begin
          report_mismatch($sformatf("last %0b on vertex %0d, expected %0b",
                                    out_last, out_visited_vertex, want.last));
        end
      end
    end
  end

  // watchdog: count cycles with no request and no result taken
  always @(posedge clk) begin
    static int stall_cycles = 0;
    if ((start && !busy) || out_strobe) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d visits pending", expected_visits.size());
      $display("adjacency_matrix_dfs_core_test: errors");
      $finish;
    end
  end

  initial begin
    foreach (link_rows[r]) link_rows[r] = '0;
    vertex_count_now = amdfs_pkg::MAX_CNT;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_link_updates();
    test_vertex_count_limits();
    test_random_graphs();
    wait_for_visits();
    repeat (20) @(posedge clk);
    if (expected_visits.size() != 0) begin
      report_mismatch($sformatf("%0d visits never arrived", expected_visits.size()));
    end
    $display("covered %0d requests (%0d searches), %0d visits checked", requests_sent,
             searches_sent, visits_checked);
    $display("vertex counts from 0 through 127, self loops, removals, deep chains");
    if (error_count == 0) begin
      $display("adjacency_matrix_dfs_core_test: clean");
    end else begin
      $display("adjacency_matrix_dfs_core_test: errors");
    end
    $finish;
  end

endmodule

[adjacency_matrix_dfs_core.f]
rtl/amdfs_pkg.sv
rtl/amdfs_ram.sv
rtl/amdfs_dp.sv
rtl/amdfs_ctrl.sv
rtl/adjacency_matrix_dfs_core.sv
test/adjacency_matrix_dfs_core_test.sv
